// ===== hdl/stt_pkg.sv =====
package stt_pkg;

    // Packet layout
    localparam int PKT_W      = 64;
    localparam int WORD_W     = 32;
    localparam int WORD_LSB   = 16;
    localparam int FINE_SHIFT = 12;
    localparam int TIME_W     = 64;
    // Bits of the high word that survive the shift into a 64-bit time
    localparam int HIGH_KEEP  = TIME_W - WORD_W - FINE_SHIFT;

    // Configuration register width and index
    localparam int REG_W      = 63;
    localparam int CFG_IDX_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_THRESHOLD = 8'd0,
        CFG_MAX_DIFFERENCE = 8'd1
    } t_cfg_idx;

    localparam logic [REG_W-1:0] JUMP_THRESHOLD_RST = 63'd25600000000000;
    localparam logic [REG_W-1:0] MAX_DIFFERENCE_RST = 63'd1099511627776;

    // Header and subheader codes
    localparam logic [3:0] HDR_TIMING = 4'h4;
    localparam logic [3:0] SUB_LOW    = 4'h4;
    localparam logic [3:0] SUB_HIGH   = 4'h5;

    // Result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

    // Verdict on one high word
    typedef struct packed {
        logic              reject;
        logic              jump;
        logic [TIME_W-1:0] cand;
    } t_eval;

endpackage

// ===== hdl/split_timestamp_tracker.sv =====
// Words pass the input register, then the result register, one word per cycle while the
// output does not stall. The input register feeds the timing logic and the result register,
// which update the kept low word and global time in the same edge.
// Reset (synchronous, active low) clears both valid flags, the kept low word and the
// kept time, and loads the two threshold registers with their default values.
module split_timestamp_tracker
    import stt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PKT_W-1:0]     i_packet,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [TIME_W-1:0]    o_global_time,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PKT_W-1:0]     i_cfg_data
);

    logic                r_in_vld;
    logic [PKT_W-1:0]    r_pkt;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [TIME_W-1:0]   r_global;
    logic [WORD_W-1:0]   r_low_word;
    logic [TIME_W-1:0]   r_time_now;

    logic [REG_W-1:0]    jump_threshold;
    logic [REG_W-1:0]    max_difference;
    logic                advance;
    logic                is_timing;
    logic                is_low;
    logic                is_high;
    logic [WORD_W-1:0]   word;
    t_eval               eval;
    logic [STATUS_W-1:0] n_status;
    logic [TIME_W-1:0]   n_time_now;
    logic [WORD_W-1:0]   n_low_word;

    stt_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_jump_threshold (jump_threshold),
        .o_max_difference (max_difference)
    );

    // Move the result register when it is empty or being taken
    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pkt <= i_packet;
        end
    end

    // Decode the held word
    assign is_timing = r_pkt[PKT_W-1 -: 4] == HDR_TIMING;
    assign is_low    = is_timing && (r_pkt[PKT_W-5 -: 4] == SUB_LOW);
    assign is_high   = is_timing && (r_pkt[PKT_W-5 -: 4] == SUB_HIGH);
    assign word      = r_pkt[WORD_LSB +: WORD_W];

    stt_eval u_eval (
        .i_low_word       (r_low_word),
        .i_high_word      (word),
        .i_time_now       (r_time_now),
        .i_jump_threshold (jump_threshold),
        .i_max_difference (max_difference),
        .o_eval           (eval)
    );

    // Pick the status and the next state
    always_comb begin
        n_status   = STATUS_NONE;
        n_time_now = r_time_now;
        n_low_word = r_low_word;
        if (is_low) begin
            n_status   = STATUS_OK;
            n_low_word = word;
        end else if (is_high) begin
            if (eval.reject) begin
                n_status = STATUS_REJECT;
            end else begin
                n_status   = STATUS_OK;
                n_time_now = eval.cand;
            end
        end
    end

    // Advance the state and the result register together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_low_word <= '0;
            r_time_now <= '0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_low_word <= n_low_word;
                r_time_now <= n_time_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_status <= n_status;
            r_global <= n_time_now;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_global_time = r_global;

    // While a result is valid, the shown global time matches the kept time
    a_global_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_global_time == r_time_now)
        else $error("global time differs from kept time");

    // A rejected high word leaves the kept time alone
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_vld && is_high && eval.reject) |=> $stable(r_time_now))
        else $error("rejected high word changed the time");

    // A stored low word is the one just processed
    a_low_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_vld && is_low) |=> r_low_word == $past(word))
        else $error("low word not stored");

    // The input side stalls only behind a waiting word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without cause");

endmodule

// ===== hdl/stt_cfg.sv =====
module stt_cfg
    import stt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PKT_W-1:0]     i_cfg_data,
    output logic [REG_W-1:0]     o_jump_threshold,
    output logic [REG_W-1:0]     o_max_difference
);

    logic [REG_W-1:0] r_jump_threshold;
    logic [REG_W-1:0] r_max_difference;

    assign o_cfg_ready = 1'b1;

    // Write the addressed register, keep the low 63 bits, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_threshold <= JUMP_THRESHOLD_RST;
            r_max_difference <= MAX_DIFFERENCE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_JUMP_THRESHOLD) begin
                r_jump_threshold <= i_cfg_data[REG_W-1:0];
            end else if (i_cfg_index == CFG_MAX_DIFFERENCE) begin
                r_max_difference <= i_cfg_data[REG_W-1:0];
            end
        end
    end

    assign o_jump_threshold = r_jump_threshold;
    assign o_max_difference = r_max_difference;

endmodule

// ===== hdl/stt_eval.sv =====
module stt_eval
    import stt_pkg::*;
(
    input  logic [WORD_W-1:0] i_low_word,
    input  logic [WORD_W-1:0] i_high_word,
    input  logic [TIME_W-1:0] i_time_now,
    input  logic [REG_W-1:0]  i_jump_threshold,
    input  logic [REG_W-1:0]  i_max_difference,
    output t_eval             o_eval
);

    logic [HIGH_KEEP-1:0] high_keep;
    logic [HIGH_KEEP-1:0] high_dec;
    logic [TIME_W-1:0]    cand_raw;
    logic [TIME_W-1:0]    cand_dec;
    logic [TIME_W-1:0]    diff;
    logic [TIME_W-1:0]    rdiff;
    logic [TIME_W-1:0]    magnitude;

    // Form both candidate times; only the low bits of the high word survive the shift
    assign high_keep = i_high_word[HIGH_KEEP-1:0];
    assign high_dec  = (i_high_word == '0) ? '0 : (high_keep - HIGH_KEEP'(1));
    assign cand_raw  = {high_keep, i_low_word, {FINE_SHIFT{1'b0}}};
    assign cand_dec  = {high_dec, i_low_word, {FINE_SHIFT{1'b0}}};

    // Take the difference both ways in parallel, pick the magnitude by sign
    assign diff      = cand_raw - i_time_now;
    assign rdiff     = i_time_now - cand_raw;
    assign magnitude = diff[TIME_W-1] ? rdiff : diff;

    // Step the high word back on a forward jump; reject on the original difference
    always_comb begin
        o_eval.jump   = !diff[TIME_W-1] && (diff[REG_W-1:0] > i_jump_threshold);
        o_eval.reject = magnitude > {1'b0, i_max_difference};
        o_eval.cand   = o_eval.jump ? cand_dec : cand_raw;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import stt_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int N_PHASES        = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RUN_LIMIT_NS    = 4000000;

    // Index that no register answers to
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

    typedef enum logic {ROW_PACKET, ROW_WRITE} t_row_kind;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [PKT_W-1:0]      word;
        logic                  pinned;
        logic [STATUS_W-1:0]   status;
        logic [TIME_W-1:0]     gtime;
    } t_row;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   shown_time;
    } t_reading;

    // Directed rows: extremes, each subheader, jump correction and rejects
    localparam int N_DIRECTED = 26;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ROW_PACKET, '0, 64'h0000_0000_0000_0000, 1'b1, STATUS_NONE,   64'h0},
        '{ROW_PACKET, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STATUS_NONE,   64'h0},
        '{ROW_PACKET, '0, 64'h40FF_FFFF_FFFF_FFFF, 1'b1, STATUS_NONE,   64'h0},
        '{ROW_PACKET, '0, 64'h4FFF_FFFF_FFFF_FFFF, 1'b1, STATUS_NONE,   64'h0},
        '{ROW_PACKET, '0, 64'h4600_0000_0000_0000, 1'b1, STATUS_NONE,   64'h0},
        '{ROW_PACKET, '0, 64'h4400_0000_1000_0000, 1'b1, STATUS_OK,     64'h0},
        '{ROW_PACKET, '0, 64'h4500_0000_0000_0000, 1'b1, STATUS_OK,     64'h0100_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0001_0000, 1'b1, STATUS_REJECT, 64'h0100_0000},
        '{ROW_PACKET, '0, 64'h45FF_FFFF_FFFF_FFFF, 1'b1, STATUS_REJECT, 64'h0100_0000},
        '{ROW_PACKET, '0, 64'h44FF_FFFF_FFFF_FFFF, 1'b1, STATUS_OK,     64'h0100_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0000_0000, 1'b0, STATUS_NONE,   64'h0},
        '{ROW_WRITE, CFG_MAX_DIFFERENCE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STATUS_NONE, 64'h0},
        '{ROW_WRITE, CFG_JUMP_THRESHOLD, 64'h0, 1'b0, STATUS_NONE, 64'h0},
        '{ROW_PACKET, '0, 64'h4400_0000_1000_0000, 1'b1, STATUS_OK,     64'h0100_0000},
        // most negative difference is out of reach even at the widest limit
        '{ROW_PACKET, '0, 64'h4500_0008_0000_0000, 1'b1, STATUS_REJECT, 64'h0100_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0001_0000, 1'b1, STATUS_OK,     64'h0100_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0002_0000, 1'b1, STATUS_OK,
          64'h0000_1000_0100_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0000_0000, 1'b1, STATUS_OK,     64'h0100_0000},
        '{ROW_PACKET, '0, 64'h4400_0000_2000_0000, 1'b1, STATUS_OK,     64'h0100_0000},
        // a jump on a zero high word keeps it at zero
        '{ROW_PACKET, '0, 64'h4500_0000_0000_0000, 1'b1, STATUS_OK,     64'h0200_0000},
        '{ROW_WRITE, CFG_JUMP_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STATUS_NONE, 64'h0},
        '{ROW_WRITE, CFG_MAX_DIFFERENCE, 64'h0, 1'b0, STATUS_NONE, 64'h0},
        '{ROW_PACKET, '0, 64'h4500_0000_0000_0000, 1'b1, STATUS_OK,     64'h0200_0000},
        '{ROW_PACKET, '0, 64'h4500_0000_0001_0000, 1'b1, STATUS_REJECT, 64'h0200_0000},
        '{ROW_WRITE, CFG_IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STATUS_NONE, 64'h0},
        '{ROW_PACKET, '0, 64'h4500_0000_0001_0000, 1'b1, STATUS_REJECT, 64'h0200_0000}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PKT_W-1:0]     i_packet;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STATUS_W-1:0]  o_status;
    logic [TIME_W-1:0]    o_global_time;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PKT_W-1:0]     i_cfg_data;

    // Clock model state and limits
    logic [WORD_W-1:0] kept_low   = '0;
    logic [TIME_W-1:0] kept_time  = '0;
    logic [REG_W-1:0]  jump_limit = JUMP_THRESHOLD_RST;
    logic [REG_W-1:0]  step_limit = MAX_DIFFERENCE_RST;

    t_reading due_readings[$];
    int       mismatches = 0;

    // Typed expectation for the directed word being driven
    logic                pin_result = 1'b0;
    logic [STATUS_W-1:0] pin_status;
    logic [TIME_W-1:0]   pin_time;

    split_timestamp_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_packet      (i_packet),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_global_time (o_global_time),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the clock model by one packet and return its status
    function automatic logic [STATUS_W-1:0] track_packet(input logic [PKT_W-1:0] pkt);
        logic [3:0]          hdr;
        logic [3:0]          sub;
        logic [WORD_W-1:0]   high;
        logic [TIME_W-1:0]   cand;
        logic [TIME_W-1:0]   diff;
        logic [TIME_W-1:0]   mag;
        logic [STATUS_W-1:0] st;
        hdr  = pkt[PKT_W-1 -: 4];
        sub  = pkt[PKT_W-5 -: 4];
        high = pkt[WORD_LSB +: WORD_W];
        st   = STATUS_NONE;
        if (hdr == HDR_TIMING && sub == SUB_LOW) begin
            kept_low = high;
            st = STATUS_OK;
        end else if (hdr == HDR_TIMING && sub == SUB_HIGH) begin
            cand = {high, kept_low} << FINE_SHIFT;
            diff = cand - kept_time;
            // pull back a high word that ran one ahead
            if (!diff[TIME_W-1] && diff > {1'b0, jump_limit}) begin
                if (high != 0)
                    high = high - 1;
                cand = {high, kept_low} << FINE_SHIFT;
            end
            // reject on the first difference, not the corrected one
            mag = diff[TIME_W-1] ? ~diff + 1'b1 : diff;
            if (mag > {1'b0, step_limit}) begin
                st = STATUS_REJECT;
            end else begin
                kept_time = cand;
                st = STATUS_OK;
            end
        end
        return st;
    endfunction

    function automatic logic [PKT_W-1:0] make_packet(input logic [3:0] hdr,
                                                      input logic [3:0] sub,
                                                      input logic [WORD_W-1:0] word);
        return {hdr, sub, 8'($urandom), word, 16'($urandom)};
    endfunction

    // Pick a limit: extremes, defaults, full range or near the usual time scale
    function automatic logic [REG_W-1:0] random_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return '0;
        else if (sel < 30)
            return '1;
        else if (sel < 42)
            return JUMP_THRESHOLD_RST;
        else if (sel < 54)
            return MAX_DIFFERENCE_RST;
        else if (sel < 70)
            return REG_W'({$urandom, $urandom});
        else
            return (REG_W'(1) << $urandom_range(24, 48)) + REG_W'($urandom);
    endfunction

    // Check accepted results, predict accepted packets, track register writes
    always @(posedge i_clk) begin : scoreboard
        t_reading            got;
        t_reading            want;
        logic [STATUS_W-1:0] st;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_readings.size() == 0) begin
                    $error("result word with nothing expected: status %0d, o_global_time %h",
                           o_status, o_global_time);
                    mismatches++;
                end else begin
                    got = due_readings.pop_front();
                    if (o_status !== got.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               got.status, o_status);
                        mismatches++;
                    end
                    if (o_global_time !== got.shown_time) begin
                        $error("o_global_time mismatch: expected %h, actual %h",
                               got.shown_time, o_global_time);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                st = track_packet(i_packet);
                if (pin_result)
                    want = '{pin_status, pin_time};
                else
                    want = '{st, kept_time};
                due_readings.insert(due_readings.size(), want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_JUMP_THRESHOLD: jump_limit = i_cfg_data[REG_W-1:0];
                    CFG_MAX_DIFFERENCE: step_limit = i_cfg_data[REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver stall pattern, switching between styles in runs of random length
    initial begin : out_stall_pattern
        t_stall_mode mode;
        int          run;
        i_out_stall = 1'b0;
        mode = STALL_NONE;
        run = 0;
        forever begin
            @(negedge i_clk);
            if (run == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                run = $urandom_range(5, 60);
            end
            run--;
            case (mode)
                STALL_NONE:   i_out_stall = 1'b0;
                STALL_LIGHT:  i_out_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  i_out_stall = ($urandom_range(0, 3) != 0);
                default:      i_out_stall = ~i_out_stall;
            endcase
        end
    end

    // Drive one packet word and hold it until taken; valid stays high afterwards
    task automatic send_word(input logic [PKT_W-1:0] pkt, input logic pin,
                             input logic [STATUS_W-1:0] st, input logic [TIME_W-1:0] gt);
        pin_result = pin;
        pin_status = st;
        pin_time   = gt;
        i_packet   = pkt;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        pin_result = 1'b0;
    endtask

    // Write a register once every outstanding result has come back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PKT_W-1:0] data);
        i_in_valid = 1'b0;
        while (due_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : stimulus
        int                sel;
        int                gap;
        int                burst_left;
        logic [51:0]       cur;
        logic [WORD_W-1:0] word;
        logic [3:0]        sub;
        logic [PKT_W-1:0]  pkt;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_packet    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE)
                write_register(DIRECTED[r].index, DIRECTED[r].word);
            else
                send_word(DIRECTED[r].word, DIRECTED[r].pinned,
                          DIRECTED[r].status, DIRECTED[r].gtime);
        end

        // Random phases, each under its own pair of limits
        burst_left = $urandom_range(1, 40);
        for (int phase = 0; phase < N_PHASES; phase++) begin
            if ($urandom_range(0, 1)) begin
                write_register(CFG_JUMP_THRESHOLD, {1'($urandom), random_limit()});
                write_register(CFG_MAX_DIFFERENCE, {1'($urandom), random_limit()});
            end else begin
                write_register(CFG_MAX_DIFFERENCE, {1'($urandom), random_limit()});
                write_register(CFG_JUMP_THRESHOLD, {1'($urandom), random_limit()});
            end
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_MAX_DIFFERENCE + CFG_IDX_W'($urandom_range(1, 254)),
                               {$urandom, $urandom});

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cur = kept_time[TIME_W-1:FINE_SHIFT];
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    // raw noise, mostly other headers
                    pkt = {$urandom, $urandom};
                end else if (sel < 20) begin
                    do sub = 4'($urandom);
                    while (sub == SUB_LOW || sub == SUB_HIGH);
                    pkt = make_packet(HDR_TIMING, sub, $urandom);
                end else if (sel < 55) begin
                    // low word a little ahead of the kept time, sometimes anywhere
                    if (sel < 50)
                        word = cur[31:0] + WORD_W'($urandom_range(0, 1 << 20));
                    else
                        word = $urandom;
                    pkt = make_packet(HDR_TIMING, SUB_LOW, word);
                end else begin
                    // high word around the kept one, mostly the same or the next value
                    word = WORD_W'(cur[51:32]);
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        word = word - 1;
                    else if (sel >= 5 && sel <= 7)
                        word = word + 1;
                    else if (sel == 8)
                        word = word + 2;
                    else if (sel == 9)
                        word = $urandom;
                    pkt = make_packet(HDR_TIMING, SUB_HIGH, word);
                end
                send_word(pkt, 1'b0, STATUS_NONE, '0);

                // Bursts with random gaps, some of them gapless
                burst_left--;
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        i_in_valid = 1'b0;
                        repeat (gap) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        // Drain
        i_in_valid = 1'b0;
        while (due_readings.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/stt_pkg.sv
hdl/stt_cfg.sv
hdl/stt_eval.sv
hdl/split_timestamp_tracker.sv
test/testbench.sv
